### design/fltu_pkg.sv
package fltu_pkg;

   // Field widths fixed by the page table format.
   localparam int ADDR_W  = 52;
   localparam int VA_W    = 48;
   localparam int PPN_W   = 40;
   localparam int FLAG_W  = 12;
   localparam int IDX_W   = 9;
   localparam int ENTRY_W = 64;
   localparam int VPN_W   = 36;

   // Entry flag bits.
   localparam logic [FLAG_W-1:0] PTE_P = 12'h001;
   localparam logic [FLAG_W-1:0] PTE_W = 12'h002;
   localparam logic [FLAG_W-1:0] PTE_U = 12'h004;
   localparam logic [FLAG_W-1:0] PTE_TABLE = PTE_P | PTE_W | PTE_U;

   // Operation codes.
   localparam logic [1:0] OP_MAP   = 2'd0;
   localparam logic [1:0] OP_UNMAP = 2'd1;
   localparam logic [1:0] OP_ALLOC = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_PAGES    = 2'd1;
   localparam logic [1:0] ST_NOT_PRESENT = 2'd2;
   localparam logic [1:0] ST_OUTSIDE     = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROOT,
      S_READ,
      S_EVAL,
      S_CLEAR,
      S_LEAF,
      S_RESP
   } fltu_state_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] root_addr;
      logic [VA_W-1:0]   virt_addr;
      logic [ADDR_W-1:0] phys_addr;
      logic [FLAG_W-1:0] leaf_flags;
      logic              is_active_root;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] new_root_addr;
      logic              flush_request;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       root_enter;
      logic       alloc_root;
      logic       read_entry;
      logic       update_entry;
      logic       link_entry;
      logic       descend;
      logic       clear_step;
      logic       step_down;
      logic       write_leaf;
      logic       set_status;
      logic [1:0] status;
      logic       rsp_load;
   } fltu_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       root_ok;
      logic       entry_present;
      logic       entry_ok;
      logic       pool_full;
      logic       clear_last;
      logic       level_one;
   } fltu_stat_type;

endpackage

### design/fltu_if.sv
interface fltu_req_if;
   import fltu_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [ADDR_W-1:0] root_addr;
   logic [VA_W-1:0]   virt_addr;
   logic [ADDR_W-1:0] phys_addr;
   logic [FLAG_W-1:0] leaf_flags;
   logic              is_active_root;

   modport source (
      output valid, op, root_addr, virt_addr, phys_addr, leaf_flags, is_active_root,
      input  ready
   );
   modport sink (
      input  valid, op, root_addr, virt_addr, phys_addr, leaf_flags, is_active_root,
      output ready
   );
endinterface

interface fltu_rsp_if;
   import fltu_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [ADDR_W-1:0] new_root_addr;
   logic              flush_request;

   modport source (
      output valid, status, new_root_addr, flush_request,
      input  ready
   );
   modport sink (
      input  valid, status, new_root_addr, flush_request,
      output ready
   );
endinterface

### design/fltu_ctrl.sv
module fltu_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fltu_pkg::fltu_stat_type stat,
   output fltu_pkg::fltu_cmd_type  cmd
);
   import fltu_pkg::*;

   fltu_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_ROOT;
         end
         S_ROOT: begin
            unique case (stat.op) inside
               OP_MAP, OP_UNMAP: state_in = stat.root_ok ? S_READ : S_RESP;
               OP_ALLOC:         state_in = stat.pool_full ? S_RESP : S_CLEAR;
               default:          state_in = S_RESP;
            endcase
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (stat.op == OP_MAP && !stat.entry_present) begin
               state_in = stat.pool_full ? S_RESP : S_CLEAR;
            end else if (!stat.entry_present || !stat.entry_ok) begin
               state_in = S_RESP;
            end else begin
               state_in = stat.level_one ? S_LEAF : S_READ;
            end
         end
         S_CLEAR: begin
            if (stat.clear_last) begin
               if (stat.op == OP_ALLOC) state_in = S_RESP;
               else state_in = stat.level_one ? S_LEAF : S_READ;
            end
         end
         S_LEAF: state_in = S_RESP;
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_ROOT: begin
            unique case (stat.op) inside
               OP_MAP, OP_UNMAP: begin
                  if (stat.root_ok) begin
                     cmd.root_enter = 1'b1;
                  end else begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_OUTSIDE;
                  end
               end
               OP_ALLOC: begin
                  if (stat.pool_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_NO_PAGES;
                  end else begin
                     cmd.alloc_root = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_READ: cmd.read_entry = 1'b1;
         S_EVAL: begin
            if (stat.op == OP_MAP && stat.entry_present) begin
               cmd.update_entry = 1'b1;
               if (stat.entry_ok) begin
                  cmd.descend = 1'b1;
               end else begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_OUTSIDE;
               end
            end else if (stat.op == OP_MAP) begin
               if (stat.pool_full) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = ST_NO_PAGES;
               end else begin
                  cmd.link_entry = 1'b1;
               end
            end else if (!stat.entry_present) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NOT_PRESENT;
            end else if (!stat.entry_ok) begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_OUTSIDE;
            end else begin
               cmd.descend = 1'b1;
            end
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            cmd.step_down  = stat.clear_last && (stat.op != OP_ALLOC);
         end
         S_LEAF: cmd.write_leaf = 1'b1;
         S_RESP: cmd.rsp_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   a_clear_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) && !stat.clear_last |=> state_ff == S_CLEAR)
      else $error("page clearing sweep ended early");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("response load did not raise valid");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_ROOT)
      else $error("accepted transaction did not start");

endmodule

### design/fltu_datapath.sv
module fltu_datapath #(
   parameter int POOL_PAGES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fltu_pkg::req_payload_type         req_data,
   input  logic                              csr_wr_en,
   input  logic [fltu_pkg::PPN_W-1:0]        csr_wr_data,
   input  fltu_pkg::fltu_cmd_type            cmd,
   output fltu_pkg::fltu_stat_type           stat,
   output fltu_pkg::rsp_payload_type         rsp_data
);
   import fltu_pkg::*;

   localparam int PW    = $clog2(POOL_PAGES);
   localparam int NW    = $clog2(POOL_PAGES + 1);
   localparam int AW    = PW + IDX_W;
   localparam int DEPTH = POOL_PAGES * (2 ** IDX_W);
   localparam logic [NW-1:0] POOL_CNT = NW'(POOL_PAGES);

   logic [ENTRY_W-1:0] mem [DEPTH];

   logic [1:0]         op_ff;
   logic [PPN_W-1:0]   root_ppn_ff;
   logic [VPN_W-1:0]   vpn_ff;
   logic [PPN_W-1:0]   pa_ppn_ff;
   logic [FLAG_W-1:0]  fl_ff;
   logic               act_ff;
   logic [PPN_W-1:0]   base_ff;
   logic [NW-1:0]      nfp_ff;
   logic [PW-1:0]      page_ff;
   logic [1:0]         level_ff;
   logic [IDX_W-1:0]   cnt_ff;
   logic [ENTRY_W-1:0] rdata_ff;
   logic [1:0]         st_ff;
   logic [ADDR_W-1:0]  nr_ff;
   logic               fr_ff;
   rsp_payload_type    rsp_ff;

   logic [PPN_W-1:0]   root_off, entry_off, alloc_ppn;
   logic [IDX_W-1:0]   idx;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               wr_en;

   // Offsets into the store; an offset at or above the fill count is outside it.
   assign root_off  = root_ppn_ff - base_ff;
   assign entry_off = rdata_ff[ADDR_W-1:12] - base_ff;
   assign alloc_ppn = base_ff + PPN_W'(nfp_ff);

   always_comb begin
      case (level_ff)
         2'd0:    idx = vpn_ff[IDX_W-1:0];
         2'd1:    idx = vpn_ff[2*IDX_W-1:IDX_W];
         2'd2:    idx = vpn_ff[3*IDX_W-1:2*IDX_W];
         default: idx = vpn_ff[4*IDX_W-1:3*IDX_W];
      endcase
   end

   assign rd_addr = {page_ff, idx};
   assign wr_addr = cmd.clear_step ? {page_ff, cnt_ff} : {page_ff, idx};
   assign wr_en   = cmd.update_entry | cmd.link_entry | cmd.clear_step | cmd.write_leaf;

   always_comb begin
      wr_data = '0;
      if (cmd.update_entry) begin
         wr_data = rdata_ff | ENTRY_W'(PTE_W | PTE_U);
      end else if (cmd.link_entry) begin
         wr_data = {12'd0, alloc_ppn, PTE_TABLE};
      end else if (cmd.write_leaf && op_ff == OP_MAP) begin
         wr_data = {12'd0, pa_ppn_ff, fl_ff | PTE_P};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.read_entry) rdata_ff <= mem[rd_addr];
   end

   // Control state: configuration and the allocator.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         nfp_ff  <= '0;
      end else begin
         if (csr_wr_en) base_ff <= csr_wr_data;
         if (cmd.alloc_root || cmd.link_entry) nfp_ff <= nfp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_data.op;
         root_ppn_ff <= req_data.root_addr[ADDR_W-1:12];
         vpn_ff      <= req_data.virt_addr[VA_W-1:12];
         pa_ppn_ff   <= req_data.phys_addr[ADDR_W-1:12];
         fl_ff       <= req_data.leaf_flags;
         act_ff      <= req_data.is_active_root;
         st_ff       <= ST_OK;
         nr_ff       <= '0;
         fr_ff       <= 1'b0;
      end
      if (cmd.root_enter) begin
         page_ff  <= root_off[PW-1:0];
         level_ff <= 2'd3;
      end
      if (cmd.alloc_root || cmd.link_entry) begin
         page_ff <= nfp_ff[PW-1:0];
         cnt_ff  <= '0;
      end
      if (cmd.alloc_root) nr_ff <= {alloc_ppn, 12'd0};
      if (cmd.descend) begin
         page_ff  <= entry_off[PW-1:0];
         level_ff <= level_ff - 2'd1;
      end
      if (cmd.step_down) level_ff <= level_ff - 2'd1;
      if (cmd.clear_step) cnt_ff <= cnt_ff + 1'b1;
      if (cmd.write_leaf) fr_ff <= act_ff;
      if (cmd.set_status) st_ff <= cmd.status;
      if (cmd.rsp_load) begin
         rsp_ff.status        <= st_ff;
         rsp_ff.new_root_addr <= nr_ff;
         rsp_ff.flush_request <= fr_ff;
      end
   end

   assign stat.op            = op_ff;
   assign stat.root_ok       = root_off < PPN_W'(nfp_ff);
   assign stat.entry_present = rdata_ff[0];
   assign stat.entry_ok      = entry_off < PPN_W'(nfp_ff);
   assign stat.pool_full     = nfp_ff >= POOL_CNT;
   assign stat.clear_last    = &cnt_ff;
   assign stat.level_one     = level_ff == 2'd1;
   assign rsp_data           = rsp_ff;

   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      nfp_ff <= POOL_CNT)
      else $error("allocator ran past the pool");

   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_root || cmd.link_entry) |=> nfp_ff == NW'($past(nfp_ff) + 1'b1))
      else $error("allocator did not advance");

   a_leaf_level: assert property (@(posedge clock) disable iff (reset)
      cmd.write_leaf |-> level_ff == 2'd0)
      else $error("leaf written above the last level");

endmodule

### design/four_level_page_table_updater_core.sv
// Channel  Direction  Handshake          Payload
// req_chan in         valid/ready        op, root_addr, virt_addr, phys_addr, leaf_flags,
//                                        is_active_root
// rsp_chan out        valid/ready        status, new_root_addr, flush_request
// csr      in         csr_wr_en          csr_wr_data (store base page number)
//
// One transaction is worked on at a time. A map or unmap through existing tables runs
// the root check, a table store read and a decision for each level, and the leaf write,
// and then loads the response register. Every newly created table page is cleared one
// entry per cycle through the store's write port; an allocate-root transaction clears
// its fresh page the same way.
// Reset is synchronous and clears the controller, the allocator and the base register; the
// table store is not cleared at reset, because every page is cleared when it is allocated.
// A new request is accepted while a finished response still waits; a stalled response
// holds the controller in its response state until the output register frees up.
module four_level_page_table_updater_core #(
   parameter int POOL_PAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   fltu_req_if.sink                   req_chan,
   fltu_rsp_if.source                 rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [fltu_pkg::PPN_W-1:0] csr_wr_data
);
   import fltu_pkg::*;

   fltu_cmd_type    cmd;
   fltu_stat_type   stat;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   // Gather the request fields into one payload for the datapath.
   assign req_data.op             = req_chan.op;
   assign req_data.root_addr      = req_chan.root_addr;
   assign req_data.virt_addr      = req_chan.virt_addr;
   assign req_data.phys_addr      = req_chan.phys_addr;
   assign req_data.leaf_flags     = req_chan.leaf_flags;
   assign req_data.is_active_root = req_chan.is_active_root;

   // The controller sequences the table walk and owns both handshakes.
   fltu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the table store, the allocator and the transaction registers.
   fltu_datapath #(
      .POOL_PAGES (POOL_PAGES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_data    (rsp_data)
   );

   // The response register drives the result channel directly.
   assign rsp_chan.status        = rsp_data.status;
   assign rsp_chan.new_root_addr = rsp_data.new_root_addr;
   assign rsp_chan.flush_request = rsp_data.flush_request;

endmodule

### tb/fltu_table_mirror.sv
`timescale 1ns / 100ps

module fltu_table_mirror #(
   parameter int POOL_PAGES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   fltu_req_if                        req_mon,
   fltu_rsp_if                        rsp_mon,
   input  logic                       csr_wr_en,
   input  logic [fltu_pkg::PPN_W-1:0] csr_wr_data,
   output int unsigned                failures,
   output int unsigned                owed
);
   import fltu_pkg::*;

   localparam int ENTRIES = 512;
   localparam logic [ENTRY_W-1:0] LINK_BITS = ENTRY_W'(PTE_U | PTE_W);

   logic [ENTRY_W-1:0] tables [POOL_PAGES*ENTRIES];
   int unsigned        pages_handed_out = 0;
   logic [PPN_W-1:0]   store_base = '0;
   int unsigned        mismatches = 0;
   rsp_payload_type    responses_due [$];

   initial begin
      failures = 0;
      owed     = 0;
   end

   function automatic int unsigned entry_at(input int unsigned page,
                                            input logic [IDX_W-1:0] idx);
      return page * ENTRIES + int'(idx);
   endfunction

   // A table address is usable only if its page has already been handed out.
   function automatic logic page_in_pool(input logic [ENTRY_W-1:0] addr,
                                         output int unsigned page);
      logic [PPN_W-1:0] offset;
      offset = addr[ADDR_W-1:12] - store_base;
      page   = 32'(offset[15:0]);
      return offset < PPN_W'(pages_handed_out);
   endfunction

   function automatic logic take_page(output int unsigned page,
                                      output logic [ENTRY_W-1:0] addr);
      logic [PPN_W-1:0] ppn;
      int i;
      if (pages_handed_out >= POOL_PAGES)
         return 1'b0;
      page = pages_handed_out;
      for (i = 0; i < ENTRIES; i++)
         tables[page*ENTRIES + i] = '0;
      ppn  = store_base + PPN_W'(page);
      addr = {12'h000, ppn, 12'h000};
      pages_handed_out++;
      return 1'b1;
   endfunction

   function automatic logic [1:0] map_leaf(input logic [ADDR_W-1:0] root,
                                           input logic [VA_W-1:0] va,
                                           input logic [ADDR_W-1:0] pa,
                                           input logic [FLAG_W-1:0] flags);
      int unsigned page, fresh, at;
      logic [ENTRY_W-1:0] link, fresh_addr;
      int lvl;
      if (!page_in_pool(ENTRY_W'(root), page))
         return ST_OUTSIDE;
      for (lvl = 3; lvl >= 1; lvl--) begin
         at = entry_at(page, va[12 + IDX_W*lvl +: IDX_W]);
         if (tables[at][0]) begin
            // The user and write bits stick even if the target turns out bad.
            tables[at] = tables[at] | LINK_BITS;
            link = tables[at];
            if (!page_in_pool(link, page))
               return ST_OUTSIDE;
         end else begin
            if (!take_page(fresh, fresh_addr))
               return ST_NO_PAGES;
            tables[at] = fresh_addr | ENTRY_W'(PTE_TABLE);
            page = fresh;
         end
      end
      tables[entry_at(page, va[20:12])] = {12'h000, pa[ADDR_W-1:12], flags}
                                          | ENTRY_W'(PTE_P);
      return ST_OK;
   endfunction

   function automatic logic [1:0] unmap_leaf(input logic [ADDR_W-1:0] root,
                                             input logic [VA_W-1:0] va);
      int unsigned page;
      logic [ENTRY_W-1:0] link;
      int lvl;
      if (!page_in_pool(ENTRY_W'(root), page))
         return ST_OUTSIDE;
      for (lvl = 3; lvl >= 1; lvl--) begin
         link = tables[entry_at(page, va[12 + IDX_W*lvl +: IDX_W])];
         if (!link[0])
            return ST_NOT_PRESENT;
         if (!page_in_pool(link, page))
            return ST_OUTSIDE;
      end
      tables[entry_at(page, va[20:12])] = '0;
      return ST_OK;
   endfunction

   function automatic rsp_payload_type apply_request(input req_payload_type rq);
      rsp_payload_type outcome;
      int unsigned page;
      logic [ENTRY_W-1:0] addr;
      outcome = '0;
      case (rq.op) inside
         OP_MAP, OP_UNMAP: begin
            if (rq.op == OP_MAP)
               outcome.status = map_leaf(rq.root_addr, rq.virt_addr, rq.phys_addr,
                                         rq.leaf_flags);
            else
               outcome.status = unmap_leaf(rq.root_addr, rq.virt_addr);
            if (outcome.status == ST_OK)
               outcome.flush_request = rq.is_active_root;
         end
         OP_ALLOC: begin
            if (take_page(page, addr))
               outcome.new_root_addr = addr[ADDR_W-1:0];
            else
               outcome.status = ST_NO_PAGES;
         end
         default: ;
      endcase
      return outcome;
   endfunction

   always @(posedge clock) begin
      req_payload_type rq;
      rsp_payload_type got, want;
      if (reset) begin
         pages_handed_out = 0;
         store_base       = '0;
         responses_due.delete();
      end else begin
         if (csr_wr_en)
            store_base = csr_wr_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status        = rsp_mon.status;
            got.new_root_addr = rsp_mon.new_root_addr;
            got.flush_request = rsp_mon.flush_request;
            if (responses_due.size() == 0) begin
               $error("response transaction with nothing outstanding (status %0d)",
                      got.status);
               mismatches++;
            end else begin
               want = responses_due.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  mismatches++;
               end
               if (got.new_root_addr !== want.new_root_addr) begin
                  $error("new_root_addr: expected %h, actual %h",
                         want.new_root_addr, got.new_root_addr);
                  mismatches++;
               end
               if (got.flush_request !== want.flush_request) begin
                  $error("flush_request: expected %0d, actual %0d",
                         want.flush_request, got.flush_request);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rq.op             = req_mon.op;
            rq.root_addr      = req_mon.root_addr;
            rq.virt_addr      = req_mon.virt_addr;
            rq.phys_addr      = req_mon.phys_addr;
            rq.leaf_flags     = req_mon.leaf_flags;
            rq.is_active_root = req_mon.is_active_root;
            responses_due.push_back(apply_request(rq));
         end
      end
      owed     <= responses_due.size();
      failures <= mismatches;
   end

endmodule

### tb/four_level_page_table_updater_core_tb.sv
`timescale 1ns / 100ps

module four_level_page_table_updater_core_tb;
   import fltu_pkg::*;

   localparam int POOL_PAGES      = 16;
   localparam int RESET_CYCLES    = 11;
   // A map that has to build three tables clears three pages one entry per cycle, and the
   // limit leaves ample margin for that.
   localparam int STALL_LIMIT     = 20000;
   // Quiet time before a register write and before the verdict.
   localparam int SETTLE_CYCLES   = 40;
   localparam int ITEMS_PER_PHASE = 315;
   localparam int PHASES          = 6;
   // The op code that the block does not use; it must answer with all zeros.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Base page chosen so that store page 4 wraps around to physical page 0.
   localparam logic [PPN_W-1:0] WRAP_BASE = 40'hFF_FFFF_FFFC;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [PPN_W-1:0] csr_wr_data;
   int unsigned      failures;
   int unsigned      owed;
   int unsigned      quiet_cycles = 0;
   int unsigned      burst_left = 0;
   int unsigned      ready_cycle = 0;
   // The stimulus keeps its own copy of the base page so that it can aim root and
   // leaf addresses at pages of the store.
   logic [PPN_W-1:0] store_base = '0;

   fltu_req_if req_if();
   fltu_rsp_if rsp_if();

   four_level_page_table_updater_core #(
      .POOL_PAGES(POOL_PAGES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // The mirror watches both channels and the register port, keeps its own copy of
   // the table store, and checks every response transaction in order.
   fltu_table_mirror #(
      .POOL_PAGES(POOL_PAGES)
   ) u_mirror (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .failures   (failures),
      .owed       (owed)
   );

   always #4 clock = ~clock;

   // The receiver moves through four moods in turn: always ready, mostly ready, a fixed
   // repeating stall pattern taken from the low bits of a counter, and coin flips.
   always @(negedge clock) begin
      ready_cycle <= ready_cycle + 1;
      case (ready_cycle[9:8])
         2'd0:    rsp_if.ready <= 1'b1;
         2'd1:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
         2'd2:    rsp_if.ready <= (ready_cycle[2:0] > 3'd2);
         default: rsp_if.ready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   // Watchdog: the run is declared hung when no transaction moves on either channel
   // long enough for the quiet counter to reach STALL_LIMIT.
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   // Physical address of a store page as seen through the current base page.
   function automatic logic [ADDR_W-1:0] table_addr(input logic [PPN_W-1:0] page);
      logic [PPN_W-1:0] ppn;
      ppn = store_base + page;
      return {ppn, 12'h000};
   endfunction

   function automatic logic [VA_W-1:0] va_of(input logic [IDX_W-1:0] l4, l3, l2, l1);
      return {l4, l3, l2, l1, 12'h000};
   endfunction

   // Table indices are drawn mostly from the few values the directed part builds
   // paths on (0, 511, 9 and 10), so that random walks go deep into existing tables.
   function automatic logic [IDX_W-1:0] pick_index();
      case ($urandom_range(0, 5))
         0, 1:    return '0;
         2:       return '1;
         3:       return 9'd9;
         4:       return 9'd10;
         default: return IDX_W'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type rq;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         rq.op = OP_MAP;
      else if (pick < 85)
         rq.op = OP_UNMAP;
      else if (pick < 95)
         rq.op = OP_ALLOC;
      else
         rq.op = OP_UNUSED;
      // Roots: often the first allocated root, else any store page or one of the two pages
      // just past the pool, and now and then a fully random address.
      pick = $urandom_range(0, 99);
      if (pick < 10)
         rq.root_addr = ADDR_W'({$urandom, $urandom});
      else if (pick < 45)
         rq.root_addr = table_addr('0) | ADDR_W'($urandom_range(0, 4095));
      else
         rq.root_addr = table_addr(PPN_W'($urandom_range(0, POOL_PAGES + 1)))
                        | ADDR_W'($urandom_range(0, 4095));
      rq.virt_addr = {pick_index(), pick_index(), pick_index(), pick_index(),
                      12'($urandom)};
      // A leaf that points at a store page can later serve as a link when some
      // table page is used as a root.
      if ($urandom_range(0, 1) == 1)
         rq.phys_addr = table_addr(PPN_W'($urandom_range(0, POOL_PAGES - 1)))
                        | ADDR_W'($urandom_range(0, 4095));
      else
         rq.phys_addr = ADDR_W'({$urandom, $urandom});
      rq.leaf_flags     = FLAG_W'($urandom);
      rq.is_active_root = 1'($urandom);
      return rq;
   endfunction

   // Presents one request transaction and returns at the falling edge after it was
   // accepted. Requests go out in bursts; between bursts valid may drop. A zero gap
   // chains two bursts without dropping valid.
   task automatic issue(input req_payload_type rq);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_if.valid          <= 1'b1;
      req_if.op             <= rq.op;
      req_if.root_addr      <= rq.root_addr;
      req_if.virt_addr      <= rq.virt_addr;
      req_if.phys_addr      <= rq.phys_addr;
      req_if.leaf_flags     <= rq.leaf_flags;
      req_if.is_active_root <= rq.is_active_root;
      do
         @(posedge clock);
      while (!req_if.ready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send(input logic [1:0] op, input logic [ADDR_W-1:0] root,
                       input logic [VA_W-1:0] va, input logic [ADDR_W-1:0] pa,
                       input logic [FLAG_W-1:0] flags, input logic active);
      req_payload_type rq;
      rq.op             = op;
      rq.root_addr      = root;
      rq.virt_addr      = va;
      rq.phys_addr      = pa;
      rq.leaf_flags     = flags;
      rq.is_active_root = active;
      issue(rq);
   endtask

   // Drops valid, waits for every outstanding response, then lets the block settle.
   // Called at a falling edge.
   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      while (owed != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The base register is only written while the block is idle.
   task automatic write_store_base(input logic [PPN_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      store_base = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [PPN_W-1:0] phase_bases [PHASES];
      int phase;

      req_if.valid          = 1'b0;
      req_if.op             = OP_MAP;
      req_if.root_addr      = '0;
      req_if.virt_addr      = '0;
      req_if.phys_addr      = '0;
      req_if.leaf_flags     = '0;
      req_if.is_active_root = 1'b0;
      rsp_if.ready          = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;

      // Base pages per phase: the wrapping base, both extremes, a small shift of
      // the wrapping base (table links alias onto other pages), a random base, and
      // the wrapping base again.
      phase_bases[0] = WRAP_BASE;
      phase_bases[1] = '0;
      phase_bases[2] = '1;
      phase_bases[3] = WRAP_BASE + PPN_W'($urandom_range(1, 12));
      phase_bases[4] = PPN_W'({$urandom, $urandom});
      phase_bases[5] = WRAP_BASE;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_store_base(phase_bases[0]);

      // Directed part. Store pages are handed out in order; the comments name the
      // pages each transaction is meant to take.
      // A first root (page 0), then two full paths through it (pages 1-3 and 4-6;
      // page 4 sits at physical page 0), then a new PT under an existing PD (page 7).
      send(OP_ALLOC, '0, '0, '0, '0, 1'b1);
      send(OP_MAP, table_addr('0) | 52'hFFF, '0, '1, '0, 1'b1);
      send(OP_MAP, table_addr('0), '1, '0, '1, 1'b0);
      send(OP_MAP, table_addr('0), va_of(9'd511, 9'd511, 9'd0, 9'd5),
           table_addr(PPN_W'(7)), 12'h0F0, 1'b1);
      // Overwrite a leaf, then unmap it twice; the second unmap still succeeds.
      send(OP_MAP, table_addr('0), '0, 52'h5_5555_5555_5555, 12'h00A, 1'b0);
      send(OP_UNMAP, table_addr('0), '0, '1, '1, 1'b1);
      send(OP_UNMAP, table_addr('0), '0, '0, '0, 1'b0);
      // Unmap through a missing PML4, PDP and PD entry in turn.
      send(OP_UNMAP, table_addr('0), va_of(9'd1, 9'd0, 9'd0, 9'd0), '0, '0, 1'b1);
      send(OP_UNMAP, table_addr('0), va_of(9'd0, 9'd1, 9'd0, 9'd0), '0, '0, 1'b1);
      send(OP_UNMAP, table_addr('0), va_of(9'd0, 9'd0, 9'd1, 9'd0), '0, '0, 1'b1);
      // Roots outside the pool: a page not yet handed out, and one below the base.
      send(OP_MAP, table_addr(PPN_W'(8)), '0, '1, '1, 1'b1);
      send(OP_UNMAP, table_addr('1), '0, '0, '0, 1'b1);
      // A leaf in the PT of page 3 points back at the PDP of page 1. Walking from
      // page 3 as a root then follows that leaf as a link, ORing user and write in.
      send(OP_MAP, table_addr('0), va_of(9'd0, 9'd0, 9'd0, 9'd9), table_addr(PPN_W'(1)),
           '0, 1'b0);
      send(OP_MAP, table_addr(PPN_W'(3)), va_of(9'd9, 9'd0, 9'd0, 9'd3), '1, 12'h800,
           1'b1);
      // Same trick with a leaf aimed at a page not yet handed out: the link gets its
      // user and write bits and the walk then stops as outside the pool.
      send(OP_MAP, table_addr('0), va_of(9'd0, 9'd0, 9'd0, 9'd10),
           table_addr(PPN_W'(12)), '0, 1'b0);
      send(OP_MAP, table_addr(PPN_W'(3)), va_of(9'd10, 9'd0, 9'd0, 9'd0), '0, '0, 1'b1);
      send(OP_UNUSED, '1, '1, '1, '1, 1'b1);
      // Six more roots (pages 8-13), then a map that gets two tables (pages 14-15)
      // before the pool runs dry. After that, allocation fails and the partial path
      // stays in place, so an unmap stops at the empty PD entry.
      repeat (6) send(OP_ALLOC, table_addr('0), '1, '1, '1, 1'b1);
      send(OP_MAP, table_addr(PPN_W'(8)), '0, '1, '1, 1'b1);
      send(OP_ALLOC, '0, '0, '0, '0, 1'b0);
      send(OP_UNMAP, table_addr(PPN_W'(8)), '0, '0, '0, 1'b1);

      // Random part, one block of transactions per base page setting.
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0)
            write_store_base(phase_bases[phase]);
         repeat (ITEMS_PER_PHASE) issue(random_request());
      end

      drain();
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### files.f
design/fltu_pkg.sv
design/fltu_if.sv
design/fltu_ctrl.sv
design/fltu_datapath.sv
design/four_level_page_table_updater_core.sv
tb/fltu_table_mirror.sv
tb/four_level_page_table_updater_core_tb.sv
